/* rtl/laq_pkg.sv */
// laq_pkg: shared constants and controller/datapath interface types for the
// line assembler queue. No dependencies.
`default_nettype none

package laq_pkg;

  localparam int LINE_MAX_DEF    = 64;
  localparam int QUEUE_SLOTS_DEF = 4;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  // controller -> datapath
  typedef struct packed {
    logic acc_write;    // append rx_byte to the line being assembled
    logic acc_clear;    // drop the line being assembled
    logic drop_set;
    logic drop_clear;
    logic copy_start;   // begin moving the assembled line into a slot
    logic copy_step;    // move one word
    logic copy_commit;  // close the slot and bump the write side
    logic rd_start;     // dequeue oldest slot, latch its read limit
    logic rd_take;      // advance read position
    logic emit;
    logic emit_has;
    logic emit_cv;
    logic emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_nl;
    logic is_cr;
    logic dropping;
    logic acc_empty;
    logic acc_at_max;
    logic ring_full;
    logic ring_empty;
    logic cap_zero;
    logic limit_zero;
    logic copy_last;
    logic rdata_zero;
    logic pos_at_limit;
  } status_t;

endpackage

`default_nettype wire

/* rtl/line_assembler_queue_core.sv */
// line_assembler_queue_core: top level, controller plus datapath.
// Depends on laq_pkg, laq_ctrl, laq_datapath.
//
// Usage:
//   Command channel: drive action/rx_byte/out_capacity with start; the word is
//   taken on a rising edge with start high and busy low.
//   action 0 stores a received byte. CR is ignored; bytes build a line; LF
//   closes it into the slot ring (empty lines and lines meeting a full ring
//   are dropped). A byte arriving on a line that already holds LINE_MAX-1
//   characters throws the line away; the rest up to the next LF is ignored.
//   action 1 dequeues the oldest line and returns its characters, one result
//   per cycle, result_valid high for one cycle each, last on the final one.
//   Empty ring or zero capacity gives one result with line_found low.
// Busy and results:
//   A plain byte leaves busy low. An LF that queues a line holds busy while
//   the line is moved into its slot, one word moved per cycle.
//   A read answers from the accept for an empty ring, zero capacity or zero
//   limit, from S_FETCH if the line opens with a zero byte, else from S_EMIT;
//   then one character per cycle; busy stays high until the last result.
// Reset: rst (synchronous) empties the ring and the current line; memories
//   are not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module line_assembler_queue_core #(
  parameter int LINE_MAX    = laq_pkg::LINE_MAX_DEF,
  parameter int QUEUE_SLOTS = laq_pkg::QUEUE_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       action,
  input  wire logic [7:0] rx_byte,
  input  wire logic [6:0] out_capacity,
  output logic            result_valid,
  output logic            line_found,
  output logic            char_valid,
  output logic [7:0]      out_char,
  output logic            last
);
  import laq_pkg::*;

  cmd_t    cmd;
  status_t st;

  laq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  laq_datapath #(
    .LINE_MAX    (LINE_MAX),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .rx_byte      (rx_byte),
    .out_capacity (out_capacity),
    .result_valid (result_valid),
    .line_found   (line_found),
    .char_valid   (char_valid),
    .out_char     (out_char),
    .last         (last)
  );

  // zero-capacity read answers at once with an empty final result
  a_zero_cap: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action && (out_capacity == 7'd0)
    |=> result_valid && last && !line_found && !char_valid)
    else $error("zero-capacity read not answered with empty result");

  a_char_has: assert property (@(posedge clk) disable iff (rst)
    result_valid && char_valid |-> line_found)
    else $error("character result without line_found");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !char_valid |-> last && (out_char == CH_NUL))
    else $error("non-character result must be final and zero");

  // a read that is still emitting keeps the command side closed
  a_busy_rd: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("block idle in the middle of a read");

endmodule

`default_nettype wire

/* rtl/laq_ctrl.sv */
// laq_ctrl: sequencing state machine for the line assembler queue.
// Depends on laq_pkg (cmd_t, status_t).
`default_nettype none

module laq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            action,
  input  wire laq_pkg::status_t st,
  output laq_pkg::cmd_t        cmd,
  output logic                 busy
);
  import laq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_COPY  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state, state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!action) begin
            if (st.dropping) begin
              if (st.is_nl) begin
                cmd.drop_clear = 1'b1;
                cmd.acc_clear  = 1'b1;
              end
            end else if (st.is_cr) begin
              // ignored
            end else if (st.is_nl) begin
              if (!st.acc_empty) begin
                if (st.ring_full) begin
                  cmd.acc_clear = 1'b1;
                end else begin
                  cmd.copy_start = 1'b1;
                  state_next     = S_COPY;
                end
              end
            end else if (st.acc_at_max) begin
              cmd.acc_clear = 1'b1;
              cmd.drop_set  = 1'b1;
            end else begin
              cmd.acc_write = 1'b1;
            end
          end else if (st.cap_zero || st.ring_empty) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.rd_start = 1'b1;
            if (st.limit_zero) begin
              cmd.emit      = 1'b1;
              cmd.emit_has  = 1'b1;
              cmd.emit_last = 1'b1;
            end else begin
              state_next = S_FETCH;
            end
          end
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (st.copy_last) begin
          cmd.copy_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_FETCH: begin
        // first word of the line is on the read port now
        if (st.rdata_zero) begin
          cmd.emit      = 1'b1;
          cmd.emit_has  = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.rd_take = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_has = 1'b1;
        cmd.emit_cv  = 1'b1;
        if (st.pos_at_limit || st.rdata_zero) begin
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.rd_take = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/laq_datapath.sv */
// laq_datapath: line accumulator, slot ring memory, ring pointers and result
// registers. Depends on laq_pkg (cmd_t, status_t, character constants).
`default_nettype none

module laq_datapath #(
  parameter int LINE_MAX    = laq_pkg::LINE_MAX_DEF,
  parameter int QUEUE_SLOTS = laq_pkg::QUEUE_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire laq_pkg::cmd_t cmd,
  output laq_pkg::status_t st,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [6:0]  out_capacity,
  output logic             result_valid,
  output logic             line_found,
  output logic             char_valid,
  output logic [7:0]       out_char,
  output logic             last
);
  import laq_pkg::*;

  localparam int COL_W  = $clog2(LINE_MAX);
  localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int HELD_W = $clog2(QUEUE_SLOTS + 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(LINE_MAX - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_SLOTS - 1);

  // line being assembled
  logic [7:0]       acc_mem [LINE_MAX];
  logic [7:0]       acc_rdata;
  logic [COL_W-1:0] acc_len, acc_raddr, cidx;
  logic             dropping;

  // queued lines
  logic [7:0]        slot_mem [QUEUE_SLOTS][LINE_MAX];
  logic [7:0]        slot_rdata;
  logic [COL_W-1:0]  slot_len [QUEUE_SLOTS];
  logic [SLOT_W-1:0] rd_slot, wr_slot, cur_slot, rd_row;
  logic [SLOT_W-1:0] rd_slot_inc, wr_slot_inc;
  logic [HELD_W-1:0] held;

  // read side
  logic [COL_W-1:0] pos, limit, limit_calc, sel_len, rd_col;
  logic [6:0]       cap_m1;
  logic [7:0]       cur;

  assign rd_slot_inc = (rd_slot == SLOT_LAST) ? '0 : rd_slot + 1'b1;
  assign wr_slot_inc = (wr_slot == SLOT_LAST) ? '0 : wr_slot + 1'b1;

  assign sel_len    = slot_len[rd_slot];
  assign cap_m1     = out_capacity - 7'd1;
  assign limit_calc = (cap_m1 < 7'(sel_len)) ? COL_W'(cap_m1) : sel_len;

  assign acc_raddr = cmd.copy_start ? '0 : cidx + 1'b1;
  assign rd_row    = cmd.rd_start ? rd_slot : cur_slot;
  assign rd_col    = cmd.rd_start ? '0 : ((pos == COL_LAST) ? '0 : pos + 1'b1);

  always_comb begin
    st              = '0;
    st.is_nl        = (rx_byte == CH_NL);
    st.is_cr        = (rx_byte == CH_CR);
    st.dropping     = dropping;
    st.acc_empty    = (acc_len == '0);
    st.acc_at_max   = (acc_len == COL_LAST);
    st.ring_full    = (held == HELD_W'(QUEUE_SLOTS));
    st.ring_empty   = (held == '0);
    st.cap_zero     = (out_capacity == 7'd0);
    st.limit_zero   = (limit_calc == '0);
    st.copy_last    = (cidx == acc_len - 1'b1);
    st.rdata_zero   = (slot_rdata == CH_NUL);
    st.pos_at_limit = (pos == limit);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.acc_write) begin
      acc_mem[acc_len] <= rx_byte;
    end
    acc_rdata <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_step) begin
      slot_mem[wr_slot][cidx] <= acc_rdata;
    end
    slot_rdata <= slot_mem[rd_row][rd_col];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_commit) begin
      slot_len[wr_slot] <= acc_len;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_len      <= '0;
      dropping     <= 1'b0;
      rd_slot      <= '0;
      wr_slot      <= '0;
      held         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.acc_write) begin
        acc_len <= acc_len + 1'b1;
      end else if (cmd.acc_clear || cmd.copy_commit) begin
        acc_len <= '0;
      end
      if (cmd.drop_set) begin
        dropping <= 1'b1;
      end else if (cmd.drop_clear) begin
        dropping <= 1'b0;
      end
      if (cmd.rd_start) begin
        rd_slot <= rd_slot_inc;
        held    <= held - 1'b1;
      end else if (cmd.copy_commit) begin
        wr_slot <= wr_slot_inc;
        held    <= held + 1'b1;
      end
      result_valid <= cmd.emit;
    end
  end

  // counters and payload
  always_ff @(posedge clk) begin
    if (cmd.copy_start) begin
      cidx <= '0;
    end else if (cmd.copy_step) begin
      cidx <= cidx + 1'b1;
    end
    if (cmd.rd_start) begin
      cur_slot <= rd_slot;
      limit    <= limit_calc;
      pos      <= '0;
    end else if (cmd.rd_take) begin
      cur <= slot_rdata;
      pos <= pos + 1'b1;
    end
    line_found <= cmd.emit_has;
    char_valid <= cmd.emit_cv;
    out_char   <= cmd.emit_cv ? cur : CH_NUL;
    last       <= cmd.emit_last;
  end

endmodule

`default_nettype wire

/* tb/laq_tb_pkg.sv */
// laq_tb_pkg: command codes shared by the line assembler queue testbench and its checker.
// No dependencies.
`timescale 1ns / 1ps

package laq_tb_pkg;

  localparam logic ACT_RX   = 1'b0;  // received byte
  localparam logic ACT_READ = 1'b1;  // dequeue oldest line

endpackage

/* tb/line_assembler_queue_checker.sv */
// line_assembler_queue_checker: watches the command and result channels, predicts
// the line characters each read returns and compares them field by field.
// Depends on laq_pkg and laq_tb_pkg.
`timescale 1ns / 1ps

module line_assembler_queue_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       action,
  input  logic [7:0] rx_byte,
  input  logic [6:0] out_capacity,
  input  logic       result_valid,
  input  logic       line_found,
  input  logic       char_valid,
  input  logic [7:0] out_char,
  input  logic       last,
  output int         fail_count,
  output int         pending
);
  import laq_pkg::*;
  import laq_tb_pkg::*;

  localparam int LEN_MAX = LINE_MAX_DEF;
  localparam int SLOTS   = QUEUE_SLOTS_DEF;
  localparam int REPORT_MAX = 40;

  typedef struct packed {
    logic       line_found;
    logic       char_valid;
    logic [7:0] out_char;
    logic       last;
  } line_result_t;

  line_result_t expected_chars[$];

  // line being assembled
  logic [7:0]  cur_line [LEN_MAX];
  int unsigned cur_len;
  bit          discarding;

  // queued lines
  logic [7:0]  ring_text [SLOTS][LEN_MAX];
  int unsigned ring_len [SLOTS];
  int unsigned head, tail, held;

  function automatic int unsigned next_index(int unsigned i);
    return (i + 1 >= SLOTS) ? 0 : i + 1;
  endfunction

  function automatic void take_rx_byte(logic [7:0] b);
    if (discarding) begin
      if (b == CH_NL) begin
        discarding = 1'b0;
        cur_len = 0;
      end
    end else if (b == CH_NL) begin
      // empty lines never reach the ring; a full ring loses the line
      if (cur_len != 0) begin
        if (held < SLOTS) begin
          for (int i = 0; i < cur_len; i++) ring_text[tail][i] = cur_line[i];
          ring_len[tail] = cur_len;
          tail = next_index(tail);
          held++;
        end
        cur_len = 0;
      end
    end else if (b != CH_CR) begin
      if (cur_len < LEN_MAX - 1) begin
        cur_line[cur_len] = b;
        cur_len++;
      end else begin
        cur_len = 0;
        discarding = 1'b1;
      end
    end
  endfunction

  function automatic void dequeue_line(logic [6:0] cap);
    int unsigned lim;
    int unsigned n;
    line_result_t r;
    if (cap == 0 || held == 0) begin
      r = '{line_found: 1'b0, char_valid: 1'b0, out_char: CH_NUL, last: 1'b1};
      expected_chars.push_back(r);
    end else begin
      lim = ring_len[head];
      if (lim > LEN_MAX - 1) lim = LEN_MAX - 1;
      if (lim > cap - 1) lim = cap - 1;
      n = 0;
      while (n < lim && ring_text[head][n] != CH_NUL) n++;
      if (n == 0) begin
        r = '{line_found: 1'b1, char_valid: 1'b0, out_char: CH_NUL, last: 1'b1};
        expected_chars.push_back(r);
      end
      for (int k = 0; k < n; k++) begin
        r = '{line_found: 1'b1, char_valid: 1'b1, out_char: ring_text[head][k],
              last: (k + 1 == n)};
        expected_chars.push_back(r);
      end
      head = next_index(head);
      held--;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    line_result_t want;
    if (rst) begin
      expected_chars.delete();
      cur_len = 0;
      discarding = 1'b0;
      head = 0;
      tail = 0;
      held = 0;
      fail_count = 0;
    end else begin
      // a result on this edge belongs to an earlier word, so check it first
      if (result_valid) begin
        if (expected_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $error("unexpected result: line_found %0b char_valid %0b %s %0h last %0b",
                   line_found, char_valid, "out_char", out_char, last);
        end else begin
          want = expected_chars.pop_front();
          check_field("line_found", 8'(want.line_found), 8'(line_found));
          check_field("char_valid", 8'(want.char_valid), 8'(char_valid));
          check_field("out_char", want.out_char, out_char);
          check_field("last", 8'(want.last), 8'(last));
        end
      end
      if (start && !busy) begin
        if (action == ACT_READ) dequeue_line(out_capacity);
        else take_rx_byte(rx_byte);
      end
    end
    pending <= expected_chars.size();
  end

endmodule

/* tb/tb_line_assembler_queue_core.sv */
// tb_line_assembler_queue_core: drives received bytes and line reads into the line
// assembler queue in random bursts. Depends on laq_pkg, laq_tb_pkg,
// line_assembler_queue_checker and the RTL.
`timescale 1ns / 1ps

module tb_line_assembler_queue_core;
  import laq_pkg::*;
  import laq_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_ITEMS = 360;
  localparam int DRAIN_CYCLES = 100;

  logic       clk;
  logic       rst;
  logic       start;
  logic       action;
  logic [7:0] rx_byte;
  logic [6:0] out_capacity;
  logic       busy;
  logic       result_valid;
  logic       line_found;
  logic       char_valid;
  logic [7:0] out_char;
  logic       last;
  int         fail_count;
  int         pending;

  int cycles = 0;
  int items = 0;
  int burst_left = 0;

  line_assembler_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .rx_byte      (rx_byte),
    .out_capacity (out_capacity),
    .result_valid (result_valid),
    .line_found   (line_found),
    .char_valid   (char_valid),
    .out_char     (out_char),
    .last         (last)
  );

  line_assembler_queue_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .rx_byte      (rx_byte),
    .out_capacity (out_capacity),
    .result_valid (result_valid),
    .line_found   (line_found),
    .char_valid   (char_valid),
    .out_char     (out_char),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Hold one word on the command port until taken, then maybe idle a while.
  task automatic put_word(input logic act, input logic [7:0] b, input logic [6:0] cap,
                          input bit counted);
    start <= 1'b1;
    action <= act;
    rx_byte <= b;
    out_capacity <= cap;
    do @(posedge clk); while (busy);
    if (counted) items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      action <= 1'($urandom_range(0, 1));
      rx_byte <= 8'($urandom);
      out_capacity <= 7'($urandom_range(0, 64));
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Send n characters then a newline; a line that runs past the line limit is thrown away by the block.
  task automatic send_line(input int unsigned n);
    logic [7:0] ch;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) ch = 8'($urandom);
      else if (pick == 1) ch = CH_CR;
      else if (pick == 2) ch = CH_NUL;
      else ch = 8'($urandom_range(8'h20, 8'h7E));
      put_word(ACT_RX, ch, 7'($urandom_range(0, 64)), i < LINE_MAX_DEF && ch != CH_CR);
    end
    put_word(ACT_RX, CH_NL, 7'($urandom_range(0, 64)), 1'b1);
  endtask

  initial begin
    int unsigned pick;
    int unsigned read_pct;
    int unsigned next_mix;
    logic [6:0] cap;
    logic [7:0] b;

    start <= 1'b0;
    action <= ACT_RX;
    rx_byte <= 8'h00;
    out_capacity <= 7'd0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // read on an empty ring
    put_word(ACT_READ, 8'h00, 7'd5, 1'b1);
    // CR is skipped inside a line
    put_word(ACT_RX, 8'h41, 7'd0, 1'b1);
    put_word(ACT_RX, CH_CR, 7'd0, 1'b0);
    put_word(ACT_RX, 8'hFF, 7'd0, 1'b1);
    put_word(ACT_RX, 8'h42, 7'd0, 1'b1);
    put_word(ACT_RX, CH_NL, 7'd0, 1'b1);
    // empty line is never queued
    put_word(ACT_RX, CH_NL, 7'd0, 1'b1);
    // zero capacity leaves the ring alone; capacity 1 dequeues but returns no characters
    put_word(ACT_READ, 8'hFF, 7'd0, 1'b1);
    put_word(ACT_READ, 8'h00, 7'd1, 1'b1);
    // zero byte inside a line cuts the read short
    put_word(ACT_RX, 8'h80, 7'd64, 1'b1);
    put_word(ACT_RX, CH_NUL, 7'd64, 1'b1);
    put_word(ACT_RX, 8'h7F, 7'd64, 1'b1);
    put_word(ACT_RX, CH_NL, 7'd64, 1'b1);
    put_word(ACT_READ, 8'h00, 7'd64, 1'b1);
    // five lines into four slots: the last one is lost
    for (int i = 0; i < 5; i++) begin
      put_word(ACT_RX, 8'(8'h70 + i), 7'd0, 1'b1);
      put_word(ACT_RX, CH_NL, 7'd0, 1'b1);
    end
    put_word(ACT_READ, 8'h00, 7'd64, 1'b1);

    // longest line that fits, then one that overflows and is dropped
    send_line(LINE_MAX_DEF - 1);
    send_line(LINE_MAX_DEF + 2);
    repeat (QUEUE_SLOTS_DEF) put_word(ACT_READ, 8'h00, 7'd64, 1'b1);

    read_pct = 30;
    next_mix = items;
    while (items < TARGET_ITEMS) begin
      // shift the read/write balance now and then so the ring fills and drains
      if (items >= next_mix) begin
        read_pct = $urandom_range(10, 60);
        next_mix = items + $urandom_range(20, 50);
      end
      pick = $urandom_range(0, 99);
      if (pick < read_pct) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) cap = 7'd0;
        else if (pick == 1) cap = 7'd1;
        else if (pick == 2) cap = 7'd64;
        else if (pick == 3) cap = 7'($urandom_range(2, 5));
        else cap = 7'($urandom_range(0, 64));
        put_word(ACT_READ, 8'($urandom), cap, 1'b1);
      end else if (pick < 90) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_line(0);
        else if (pick == 1) send_line($urandom_range(50, 70));
        else send_line($urandom_range(1, 10));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(0, 5);
          if (pick == 0) b = CH_NL;
          else if (pick == 1) b = CH_CR;
          else b = 8'($urandom);
          put_word(ACT_RX, b, 7'($urandom_range(0, 64)), b != CH_CR);
        end
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
